### src/pkic_pkg.sv
// Package for the permutation inversion counter: sizes, the request and
// status structs passed between the top level and the engine, and the row
// length helper. Depends on nothing.
`default_nettype none

package pkic_pkg;

	// Largest number of elements a query may name.
	localparam int MAX_N     = 16;
	// Entries in one table row: inversions run from 0 to MAX_N(MAX_N-1)/2.
	localparam int ROW_DEPTH = MAX_N * (MAX_N - 1) / 2 + 1;
	localparam int IDX_W     = $clog2(ROW_DEPTH + 1);
	localparam int N_W       = 5;
	localparam int K_W       = 8;
	localparam int COUNT_W   = 45;

	typedef struct packed {
		logic [N_W-1:0] n;
		logic [K_W-1:0] k;
	} req_t;

	typedef struct packed {
		logic idle;
		logic done;
	} status_t;

	// Highest inversion count possible with m elements, m(m-1)/2.
	function automatic logic [IDX_W-1:0] row_top(input logic [N_W-1:0] m);
		logic [2*N_W-1:0] prod;
		prod = {{N_W{1'b0}}, m} * {{N_W{1'b0}}, m - N_W'(1)};
		return IDX_W'(prod >> 1);
	endfunction

endpackage

`default_nettype wire

### src/pkic_engine.sv
// Sequencer and datapath of the inversion counter: two ping-pong table rows
// in one memory and a single shared adder/subtractor.
// Depends on pkic_pkg.
`default_nettype none

module pkic_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire pkic_pkg::req_t              req,
	input  wire logic                        take,
	output      pkic_pkg::status_t           status,
	output      logic [pkic_pkg::COUNT_W-1:0] result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_ROW,
		S_ADD,
		S_SUB,
		S_WR,
		S_FETCH,
		S_DONE
	} state_t;

	localparam int ADDR_W = pkic_pkg::IDX_W + 1;

	state_t                          state_q;
	logic [pkic_pkg::N_W-1:0]        n_q;
	logic [pkic_pkg::N_W-1:0]        m_q;
	logic [pkic_pkg::K_W-1:0]        k_q;
	logic [pkic_pkg::IDX_W-1:0]      j_q;
	logic [pkic_pkg::IDX_W-1:0]      old_top_q;
	logic [pkic_pkg::IDX_W-1:0]      new_top_q;
	logic                            bank_q;
	logic                            zero_q;
	logic [pkic_pkg::COUNT_W-1:0]    run_q;

	logic [pkic_pkg::COUNT_W-1:0]    row_mem [2**ADDR_W];
	logic [pkic_pkg::COUNT_W-1:0]    rd_q;
	logic [ADDR_W-1:0]               raddr;
	logic [ADDR_W-1:0]               waddr;
	logic [pkic_pkg::COUNT_W-1:0]    wdata;
	logic                            we;

	logic [pkic_pkg::IDX_W-1:0]      m_idx;
	logic [pkic_pkg::IDX_W-1:0]      j_minus_m;
	logic                            add_en;
	logic                            sub_en;
	logic [pkic_pkg::COUNT_W-1:0]    alu_b;
	logic [pkic_pkg::COUNT_W-1:0]    alu_y;
	logic                            trivial;

	assign m_idx     = pkic_pkg::IDX_W'(m_q);
	assign j_minus_m = j_q - m_idx;
	assign add_en    = (j_q <= old_top_q);
	assign sub_en    = (j_q >= m_idx) && (j_minus_m <= old_top_q);

	// The one arithmetic unit: adds the entry entering the window, then
	// subtracts the entry leaving it.
	assign alu_b = ((state_q == S_SUB) ? add_en : sub_en) ? rd_q : '0;
	assign alu_y = (state_q == S_WR) ? (run_q - alu_b) : (run_q + alu_b);

	assign trivial = (req.n == '0) || (int'(req.n) > pkic_pkg::MAX_N) ||
		(int'(req.k) > int'(pkic_pkg::row_top(req.n)));

	always_comb begin
		case (state_q)
			S_ADD:           raddr = {bank_q, j_q};
			S_SUB:           raddr = {bank_q, j_minus_m};
			S_FETCH, S_DONE: raddr = {bank_q, pkic_pkg::IDX_W'(k_q)};
			default:         raddr = '0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = {~bank_q, j_q};
		wdata = alu_y;
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = {bank_q, {pkic_pkg::IDX_W{1'b0}}};
				wdata = pkic_pkg::COUNT_W'(1);
			end
			S_WR: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			row_mem[waddr] <= wdata;
		end
		rd_q <= row_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			m_q       <= '0;
			k_q       <= '0;
			j_q       <= '0;
			old_top_q <= '0;
			new_top_q <= '0;
			bank_q    <= 1'b0;
			zero_q    <= 1'b0;
			run_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q       <= req.n;
						k_q       <= req.k;
						m_q       <= pkic_pkg::N_W'(2);
						bank_q    <= 1'b0;
						old_top_q <= '0;
						zero_q    <= trivial;
						state_q   <= trivial ? S_DONE : S_INIT;
					end
				end
				S_INIT: begin
					state_q <= (n_q < pkic_pkg::N_W'(2)) ? S_FETCH : S_ROW;
				end
				S_ROW: begin
					new_top_q <= pkic_pkg::row_top(m_q);
					j_q       <= '0;
					run_q     <= '0;
					state_q   <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_SUB;
				end
				S_SUB: begin
					run_q   <= alu_y;
					state_q <= S_WR;
				end
				S_WR: begin
					run_q <= alu_y;
					if (j_q == new_top_q) begin
						bank_q    <= ~bank_q;
						old_top_q <= new_top_q;
						m_q       <= m_q + pkic_pkg::N_W'(1);
						state_q   <= (m_q == n_q) ? S_FETCH : S_ROW;
					end else begin
						j_q     <= j_q + pkic_pkg::IDX_W'(1);
						state_q <= S_ADD;
					end
				end
				S_FETCH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign status.idle = (state_q == S_IDLE);
	assign status.done = (state_q == S_DONE);
	assign result      = zero_q ? '0 : rd_q;

	// An entry is never written past the end of the row being built.
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> (j_q <= new_top_q))
		else $error("row index ran past the row end");

	// Rows are only started for m between two and n.
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW) |-> ((m_q >= pkic_pkg::N_W'(2)) && (m_q <= n_q)))
		else $error("row started outside 2..n");

	// A non-trivial answer is read from an entry of the finished row.
	a_final_written: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && !zero_q) |-> (int'(k_q) <= int'(old_top_q)))
		else $error("answer read beyond the finished row");

	// Once the result is taken the engine is free for the next query.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && take) |=> (state_q == S_IDLE))
		else $error("engine did not return to idle after handing over");

endmodule

`default_nettype wire

### src/perm_k_inversion_counter_top.sv
// One query at a time: the single memory read port and shared adder take every table entry
// through add, subtract and write steps, and out-of-range queries skip the table and answer
// zero. A finished result waits in the output register while the next query is taken.
// Reset (arst_n low) empties the output register and idles the engine; the table rows
// are not cleared, as every entry is written before it is read.
`default_nettype none

module perm_k_inversion_counter_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire logic [pkic_pkg::N_W-1:0]     n,
	input  wire logic [pkic_pkg::K_W-1:0]     k,
	output      logic                         out_valid,
	input  wire logic                         out_ready,
	output      logic [pkic_pkg::COUNT_W-1:0] count
);

	pkic_pkg::req_t               req;
	pkic_pkg::status_t            eng_status;
	logic [pkic_pkg::COUNT_W-1:0] eng_result;
	logic                         load;
	logic                         out_valid_q;
	logic [pkic_pkg::COUNT_W-1:0] count_q;

	assign req.n = n;
	assign req.k = k;

	// The engine takes a query whenever it is idle, even while an earlier
	// result is still waiting in the output register.
	assign in_ready = eng_status.idle;

	// A finished result moves into the output register as soon as that
	// register is empty or is being emptied by a transfer in this cycle.
	assign load = eng_status.done && (!out_valid_q || out_ready);

	pkic_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid),
		.req    (req),
		.take   (load),
		.status (eng_status),
		.result (eng_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The payload register needs no reset; it is only read while valid.
	always_ff @(posedge clk) begin
		if (load) begin
			count_q <= eng_result;
		end
	end

	assign out_valid = out_valid_q;
	assign count     = count_q;

endmodule

`default_nettype wire

### tb/pkic_count_checker.sv
// Checker for the permutation inversion counter: watches both channels, works out the
// expected count of every query taken and compares it with the count returned.
// Depends on pkic_pkg for the field widths and the largest number of elements.
module pkic_count_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [pkic_pkg::N_W-1:0]     n,
	input  wire logic [pkic_pkg::K_W-1:0]     k,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [pkic_pkg::COUNT_W-1:0] count,
	output int                                mismatch_count,
	output int                                counts_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import pkic_pkg::*;

	logic [COUNT_W-1:0] expected_counts [$];

	// Mahonian number: permutations of qn elements with exactly qk inversions, built
	// row by row, each entry being a sum over a window of up to m entries of the row below.
	function automatic logic [COUNT_W-1:0] mahonian_count(input logic [N_W-1:0] qn,
			input logic [K_W-1:0] qk);
		longint unsigned lower [ROW_DEPTH];
		longint unsigned upper [ROW_DEPTH];
		int m;
		int j;
		int i;
		int top;
		if (qn == 0 || qn > MAX_N) begin
			return '0;
		end
		top = qn * (qn - 1) / 2;
		if (qk > top) begin
			return '0;
		end
		for (j = 0; j < ROW_DEPTH; j++) begin
			lower[j] = 0;
		end
		lower[0] = 1;
		for (m = 2; m <= qn; m++) begin
			for (j = 0; j < ROW_DEPTH; j++) begin
				upper[j] = 0;
				for (i = 0; i < m && i <= j; i++) begin
					upper[j] += lower[j - i];
				end
			end
			lower = upper;
		end
		return COUNT_W'(lower[qk]);
	endfunction

	// The result side is checked before the query side so that a transfer on both
	// channels at one edge pairs the result with the older query.
	always @(posedge clk) begin : watch
		logic [COUNT_W-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_counts.size() == 0) begin
					$display("%0t: count %0d returned with no query outstanding", $time, count);
					mismatch_count++;
				end else begin
					want = expected_counts.pop_front();
					if (count !== want) begin
						$display("%0t: count mismatch, expected %0d, actual %0d",
							$time, want, count);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_counts.push_back(mahonian_count(n, k));
			end
			counts_due = expected_counts.size();
		end
	end

endmodule

### tb/tb_perm_k_inversion_counter_top.sv
// Testbench top for the permutation inversion counter: drives queries, throttles the
// result channel and gives the verdict. Depends on pkic_pkg, the block itself and
// pkic_count_checker, which does all of the prediction and comparison.
module tb_perm_k_inversion_counter_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pkic_pkg::*;

	// Idling patterns, one per phase of the random stimulus.
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	localparam int HEAVY_IDLE     = 61;
	localparam int LIGHT_IDLE     = 10;
	localparam int ITEMS_PER_MODE = 60;
	localparam int PRESSURE_ITEMS = 15;
	localparam int HOLD_CYCLES    = 500;
	localparam int DRAIN_CYCLES   = 20;
	// The limit leaves several times the slowest correct run: roughly 300 queries, each at
	// the largest size, plus stalls.
	localparam int CYCLE_LIMIT    = 4000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [N_W-1:0]     n;
	logic [K_W-1:0]     k;
	logic               out_valid;
	logic               out_ready;
	logic [COUNT_W-1:0] count;

	int         mismatch_count;
	int         counts_due;
	int         cycle_count;
	idle_mode_t idle_mode;
	bit         hold_off_req;

	perm_k_inversion_counter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.n         (n),
		.k         (k),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.count     (count)
	);

	pkic_count_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.n              (n),
		.k              (k),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.count          (count),
		.mismatch_count (mismatch_count),
		.counts_due     (counts_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Percentage of cycles in which the sender holds back, for the current phase.
	function automatic int sender_idle_pct(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER: return HEAVY_IDLE;
			IDLE_BOTH:   return LIGHT_IDLE;
			default:     return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct(input idle_mode_t mode);
		case (mode)
			IDLE_RECEIVER: return HEAVY_IDLE;
			IDLE_BOTH:     return LIGHT_IDLE;
			default:       return 0;
		endcase
	endfunction

	// Offers one query and returns at the edge at which it is transferred. Valid is left
	// high afterwards: the next call either lowers it for an idle cycle or replaces the
	// payload straight away, so valid never drops and rises within one time step.
	task automatic send_query(input logic [N_W-1:0] qn, input logic [K_W-1:0] qk);
		while ($urandom_range(99) < sender_idle_pct(idle_mode)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		n        <= qn;
		k        <= qk;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// Most queries are well formed with few elements, so that the table is short to build;
	// a tenth go up to the largest size, and the rest are noise over the whole field range,
	// which covers too many elements and too many inversions.
	task automatic pick_query(output logic [N_W-1:0] qn, output logic [K_W-1:0] qk);
		int pick;
		int top;
		pick = $urandom_range(99);
		if (pick >= 88) begin
			qn = N_W'($urandom);
			qk = K_W'($urandom);
		end else begin
			if (pick < 78) begin
				qn = N_W'($urandom_range(8, 1));
			end else begin
				qn = N_W'($urandom_range(MAX_N, 9));
			end
			top = qn * (qn - 1) / 2;
			case ($urandom_range(3))
				0:       qk = K_W'(top);
				1:       qk = '0;
				default: qk = K_W'($urandom_range(top, 0));
			endcase
		end
	endtask

	task automatic wait_for_all_counts();
		@(posedge clk);
		while (counts_due != 0) begin
			@(posedge clk);
		end
	endtask

	// Result side. A hold-off request from the stimulus keeps ready low for a long,
	// counted stretch; otherwise ready follows the stall rate of the current phase.
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
				@(posedge clk);
			end
		end
	end

	// Watchdog: a run that has not ended by the limit is a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[perm_k_inversion_counter_top] ERROR");
		$finish;
	end

	// Stimulus and verdict.
	initial begin : stimulus
		logic [N_W-1:0] qn;
		logic [K_W-1:0] qk;
		idle_mode = IDLE_NONE;
		hold_off_req = 1'b0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		n        <= '0;
		k        <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed queries with no idling: the empty permutation, a single element, the
		// smallest rows, the largest row at both ends and just past its top, more elements
		// than the table allows, and the all-ones field values.
		send_query(5'd0, 8'd0);
		send_query(5'd0, 8'd255);
		send_query(5'd1, 8'd0);
		send_query(5'd1, 8'd1);
		send_query(5'd2, 8'd0);
		send_query(5'd2, 8'd1);
		send_query(5'd2, 8'd2);
		send_query(5'd3, 8'd3);
		send_query(5'd4, 8'd3);
		send_query(5'd5, 8'd10);
		send_query(5'd5, 8'd11);
		send_query(5'd8, 8'd0);
		send_query(5'd8, 8'd14);
		send_query(5'd15, 8'd105);
		send_query(5'd16, 8'd0);
		send_query(5'd16, 8'd60);
		send_query(5'd16, 8'd120);
		send_query(5'd16, 8'd121);
		send_query(5'd16, 8'd255);
		send_query(5'd17, 8'd0);
		send_query(5'd31, 8'd0);
		send_query(5'd31, 8'd255);
		in_valid <= 1'b0;

		// The sender pauses here until every count has come back.
		wait_for_all_counts();

		// Random queries under each idling pattern in turn.
		for (int mode = IDLE_NONE; mode <= IDLE_BOTH; mode++) begin
			idle_mode = idle_mode_t'(mode);
			repeat (ITEMS_PER_MODE) begin
				pick_query(qn, qk);
				send_query(qn, qk);
			end
		end

		// Back-pressure: the receiver holds off while small queries keep coming, so the
		// engine and its output register fill and the input side stops taking transfers.
		idle_mode = IDLE_NONE;
		hold_off_req = 1'b1;
		repeat (PRESSURE_ITEMS) begin
			qn = N_W'($urandom_range(4, 1));
			qk = K_W'($urandom_range(qn * (qn - 1) / 2, 0));
			send_query(qn, qk);
		end
		in_valid <= 1'b0;

		wait_for_all_counts();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && counts_due == 0) begin
			$display("[perm_k_inversion_counter_top] OK");
		end else begin
			$display("[perm_k_inversion_counter_top] ERROR");
		end
		$finish;
	end

endmodule
